FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tkft_pkg.sv
`default_nettype none

package tkft_pkg;

    // Field widths
    localparam int CFG_W = 5;
    localparam int KEY_W = 32;
    localparam int VIS_W = 32;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 5'd10;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_DUMP   = 2'd3
    } kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;       // capture item operands
        logic drop;        // delete the cell matching the item key
        logic clear;       // empty the list
        logic insert;      // sorted insert of the latched pair
        logic resp;        // load the single-result item
        logic dump_start;  // reset the rotation counter
        logic rotate;      // rotate the cell ring by one
        logic emit;        // load cell 0 as a dumped entry
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;     // list holds no entry
        logic out_free;  // output register can take an item this cycle
        logic rot_emit;  // current rotation step carries a valid entry
        logic rot_last;  // current rotation step carries the final entry
        logic rot_done;  // current rotation step is the last of the ring
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/top_k_frequency_tracker_top.sv
// Top-k frequency tracker: keeps up to max_entries (key, visits) pairs
// sorted by count in a chain of CAPACITY register cells.
// Input channel (in_valid / in_stall, kind, key, visits): an item is taken
// when in_valid is high and in_stall low. kind selects add, remove, clear
// or dump. Output channel (out_valid / out_stall): one result per item,
// or one per stored entry for a dump of a non-empty list, highest count
// first, with last set on the final one.
// Config: cfg_wr_en / cfg_wr_data write max_entries; write only while idle.
// Steps: remove or clear, then the result load; add does key compare
// and close-up, then sorted compare and insert, then the result load.
// A dump walks the whole cell ring once, one cell per cycle unless
// out_stall holds an entry step; an empty-list dump loads one result.
// Each step is one compare across all cells plus a one-cell shift.
// One item is in work at a time; in_stall is high until its results are
// loaded in the output register, which then holds while out_stall is high.
// A stalled dump pauses the ring rotation without losing place.
// Reset empties the list, drops any pending result and sets max_entries
// to 10; cell contents are not cleared.
`default_nettype none

module top_k_frequency_tracker_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [tkft_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 kind,
    input  wire logic [tkft_pkg::KEY_W-1:0] key,
    input  wire logic [tkft_pkg::VIS_W-1:0] visits,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            nonempty,
    output logic                            entry_valid,
    output logic [tkft_pkg::KEY_W-1:0]      entry_key,
    output logic [tkft_pkg::VIS_W-1:0]      entry_visits,
    output logic                            last
);

    tkft_pkg::cmd_t    cmd;
    tkft_pkg::status_t status;

    tkft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    tkft_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_key       (key),
        .in_visits    (visits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .nonempty     (nonempty),
        .entry_valid  (entry_valid),
        .entry_key    (entry_key),
        .entry_visits (entry_visits),
        .last         (last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/tkft_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module tkft_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tkft_pkg::cmd_t               cmd,
    output tkft_pkg::status_t                 status,
    input  wire logic                         cfg_wr_en,
    input  wire logic [tkft_pkg::CFG_W-1:0]   cfg_wr_data,
    input  wire logic [tkft_pkg::KEY_W-1:0]   in_key,
    input  wire logic [tkft_pkg::VIS_W-1:0]   in_visits,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              nonempty,
    output logic                              entry_valid,
    output logic [tkft_pkg::KEY_W-1:0]        entry_key,
    output logic [tkft_pkg::VIS_W-1:0]        entry_visits,
    output logic                              last
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > tkft_pkg::CFG_W) ? OCC_W : tkft_pkg::CFG_W;
    localparam logic [OCC_W-1:0] CAP_OCC  = OCC_W'(CAPACITY);
    localparam logic [OCC_W-1:0] LAST_IDX = OCC_W'(CAPACITY - 1);
    localparam logic [CMP_W-1:0] CAP_CMP  = CMP_W'(CAPACITY);

    // Cell chain: cell 0 holds the highest count, cell occ-1 the lowest
    logic [tkft_pkg::KEY_W-1:0] cell_key_reg  [CAPACITY];
    logic [tkft_pkg::KEY_W-1:0] cell_key_next [CAPACITY];
    logic [tkft_pkg::VIS_W-1:0] cell_vis_reg  [CAPACITY];
    logic [tkft_pkg::VIS_W-1:0] cell_vis_next [CAPACITY];

    logic [OCC_W-1:0]           occ_reg, occ_next;
    logic [OCC_W-1:0]           cnt_reg, cnt_next;
    logic [tkft_pkg::CFG_W-1:0] max_entries_reg;
    logic [tkft_pkg::KEY_W-1:0] op_key_reg;
    logic [tkft_pkg::VIS_W-1:0] op_visits_reg;

    logic                       out_valid_reg;
    logic                       nonempty_reg;
    logic                       entry_valid_reg;
    logic [tkft_pkg::KEY_W-1:0] entry_key_reg;
    logic [tkft_pkg::VIS_W-1:0] entry_visits_reg;
    logic                       last_reg;

    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] valid_eff;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] shift_up;
    logic [CAPACITY-1:0] ge_raw;
    logic [CAPACITY-1:0] ge;
    logic                hit;
    logic                lt_any;
    logic                full;
    logic                drop_least;
    logic                do_ins;
    logic [OCC_W-1:0]    occ_eff;
    logic [OCC_W-1:0]    occ_dec;
    logic [CMP_W-1:0]    me_ext;
    logic [CMP_W-1:0]    lim;
    logic                out_free;

    // Limit is max_entries clamped to the capacity
    always_comb
    begin
        me_ext = CMP_W'(max_entries_reg);
        lim    = (me_ext > CAP_CMP) ? CAP_CMP : me_ext;
        full   = CMP_W'(occ_reg) >= lim;
    end

    // Replace the least-visited entry only on a strictly greater count
    assign hit        = |match;
    assign lt_any     = |(valid_vec & ~ge_raw);
    assign drop_least = full && (occ_reg != '0);
    assign do_ins     = !full || drop_least && lt_any;
    assign occ_eff    = occ_reg - OCC_W'(drop_least);
    assign occ_dec    = occ_reg - OCC_W'(1);

    // Per-cell compare and shift control
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int UP = (g == CAPACITY - 1) ? 0 : g + 1;
        localparam int DN = (g == 0) ? 0 : g - 1;
        localparam logic [CAPACITY-1:0] LOW_MASK = {CAPACITY{1'b1}} >> (CAPACITY - 1 - g);

        assign valid_vec[g] = OCC_W'(g) < occ_reg;
        assign valid_eff[g] = OCC_W'(g) < occ_eff;
        assign match[g]     = valid_vec[g] && (cell_key_reg[g] == in_key);
        assign shift_up[g]  = |(match & LOW_MASK);
        assign ge_raw[g]    = cell_vis_reg[g] >= op_visits_reg;
        assign ge[g]        = valid_eff[g] && ge_raw[g];

        always_comb
        begin
            cell_key_next[g] = cell_key_reg[g];
            cell_vis_next[g] = cell_vis_reg[g];
            if (cmd.rotate || (cmd.drop && shift_up[g]))
            begin
                // close the gap, or rotate the ring during a dump
                cell_key_next[g] = cell_key_reg[UP];
                cell_vis_next[g] = cell_vis_reg[UP];
            end
            else if (cmd.insert && do_ins && !ge[g])
            begin
                if ((g == 0) || ge[DN])
                begin
                    cell_key_next[g] = op_key_reg;
                    cell_vis_next[g] = op_visits_reg;
                end
                else
                begin
                    cell_key_next[g] = cell_key_reg[DN];
                    cell_vis_next[g] = cell_vis_reg[DN];
                end
            end
        end
    end

    // Occupancy and rotation counter
    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.clear)
            occ_next = '0;
        else if (cmd.drop)
            occ_next = occ_reg - OCC_W'(hit);
        else if (cmd.insert && do_ins)
            occ_next = occ_eff + OCC_W'(1);

        cnt_next = cnt_reg;
        if (cmd.dump_start)
            cnt_next = '0;
        else if (cmd.rotate)
            cnt_next = cnt_reg + OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg         <= '0;
            cnt_reg         <= '0;
            max_entries_reg <= tkft_pkg::MAX_ENTRIES_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            cnt_reg <= cnt_next;
            if (cfg_wr_en)
                max_entries_reg <= cfg_wr_data;
            if (cmd.resp || cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Cells and operands carry no reset
    always_ff @(posedge clk)
    begin
        cell_key_reg <= cell_key_next;
        cell_vis_reg <= cell_vis_next;
        if (cmd.latch)
        begin
            op_key_reg    <= in_key;
            op_visits_reg <= in_visits;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            nonempty_reg     <= occ_reg != '0;
            entry_valid_reg  <= 1'b0;
            entry_key_reg    <= '0;
            entry_visits_reg <= '0;
            last_reg         <= 1'b1;
        end
        else if (cmd.emit)
        begin
            nonempty_reg     <= 1'b1;
            entry_valid_reg  <= 1'b1;
            entry_key_reg    <= cell_key_reg[0];
            entry_visits_reg <= cell_vis_reg[0];
            last_reg         <= status.rot_last;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Status to the controller
    assign status.empty    = occ_reg == '0;
    assign status.out_free = out_free;
    assign status.rot_emit = cnt_reg < occ_reg;
    assign status.rot_last = (cnt_reg + OCC_W'(1)) == occ_reg;
    assign status.rot_done = cnt_reg == LAST_IDX;

    assign out_valid    = out_valid_reg;
    assign nonempty     = nonempty_reg;
    assign entry_valid  = entry_valid_reg;
    assign entry_key    = entry_key_reg;
    assign entry_visits = entry_visits_reg;
    assign last         = last_reg;

    // Checks
    `ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_reg <= CAP_OCC, "occupancy above capacity")
    `ASSERT_IMPLIES(a_key_unique, clk, rst_n, cmd.drop, $onehot0(match), "key held twice")
    `ASSERT_IMPLIES(a_emit_ok, clk, rst_n, cmd.emit, out_free && status.rot_emit, "bad emit")
    `ASSERT_NEXT(a_drop_cnt, clk, rst_n, cmd.drop && hit, occ_reg == $past(occ_dec), "drop miscount")

endmodule

`default_nettype wire

FILE: rtl/core/tkft_ctrl.sv
`default_nettype none

module tkft_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire tkft_pkg::status_t status,
    output tkft_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_RESP = 4'b0100,
        S_DUMP = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    tkft_pkg::kind_t kind_dec;
    logic            accept;

    assign kind_dec = tkft_pkg::kind_t'(kind);
    assign in_stall = state_reg != S_IDLE;
    assign accept   = in_valid && (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch = 1'b1;
                    case (kind_dec)
                        tkft_pkg::KIND_ADD:
                        begin
                            cmd.drop   = 1'b1;
                            state_next = S_INS;
                        end
                        tkft_pkg::KIND_REMOVE:
                        begin
                            cmd.drop   = 1'b1;
                            state_next = S_RESP;
                        end
                        tkft_pkg::KIND_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = S_RESP;
                        end
                        tkft_pkg::KIND_DUMP:
                        begin
                            if (status.empty)
                                state_next = S_RESP;
                            else
                            begin
                                cmd.dump_start = 1'b1;
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_INS:
            begin
                cmd.insert = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.resp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                // one ring step per cycle; entry steps wait for the output
                if (!status.rot_emit)
                begin
                    cmd.rotate = 1'b1;
                    if (status.rot_done)
                        state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.rotate = 1'b1;
                    cmd.emit   = 1'b1;
                    if (status.rot_done)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire
